FILE: sv/assert_macros.svh
// Assertion macros used by the port-level checker.
// TST_ASSERT is disabled while reset is high; TST_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tst: assertion failed");

`define TST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tst: assertion failed");

`endif

FILE: sv/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Types and constants of the topic subscription table.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int DEF_MAX_TOPICS      = 16;
  localparam int DEF_MAX_SUBSCRIBERS = 16;
  localparam int DEF_KEY_BITS        = 64;
  localparam int DEF_CLIENT_BITS     = 10;

  localparam int KEY_PORT_W    = 64;
  localparam int CLIENT_PORT_W = 10;

  typedef enum logic {
    OP_SUBSCRIBE   = 1'b0,
    OP_UNSUBSCRIBE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_NEW_TOPIC = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_ALREADY   = 3'd2,
    STAT_REMOVED   = 3'd3,
    STAT_NO_TOPIC  = 3'd4,
    STAT_NOT_SUB   = 3'd5,
    STAT_FULL      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_TMISS,
    S_CSCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic    success;
    status_t status;
  } result_t;

endpackage

FILE: sv/tst_ram.sv
// ----------------------------------------------------------------------------
// tst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tst_out_buf.sv
// ----------------------------------------------------------------------------
// tst_out_buf
// Result register plus one pending slot, so a new request can be taken while
// a result word is still waiting downstream.
// ----------------------------------------------------------------------------
module tst_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  tst_pkg::result_t res,
  output logic             pend_full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             success,
  output logic [2:0]       status
);

  logic             pend_valid;
  tst_pkg::result_t pend_q;
  tst_pkg::result_t out_q;
  logic             out_free;

  assign out_free  = !out_valid || !out_stall;
  assign pend_full = pend_valid;
  assign success   = out_q.success;
  assign status    = out_q.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= res_valid;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_q  <= pend_q;
        pend_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (res_valid) begin
      pend_q <= res;
    end
  end

endmodule

FILE: sv/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl
// Request sequencer: scans the topic RAM, then the chosen subscriber list,
// appends or removes with compaction, and writes counts back.
// Topic RAM entry layout: {subscriber count, key}.
// ----------------------------------------------------------------------------
module tst_ctrl #(
  parameter int MAX_TOPICS      = tst_pkg::DEF_MAX_TOPICS,
  parameter int MAX_SUBSCRIBERS = tst_pkg::DEF_MAX_SUBSCRIBERS,
  parameter int KEY_BITS        = tst_pkg::DEF_KEY_BITS,
  parameter int CLIENT_BITS     = tst_pkg::DEF_CLIENT_BITS,
  localparam int TI_W = $clog2(MAX_TOPICS),
  localparam int SI_W = $clog2(MAX_SUBSCRIBERS),
  localparam int SC_W = $clog2(MAX_SUBSCRIBERS + 1),
  localparam int TE_W = SC_W + KEY_BITS,
  localparam int SA_W = TI_W + SI_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [tst_pkg::CLIENT_PORT_W-1:0]  client_id,
  input  logic [tst_pkg::KEY_PORT_W-1:0]     topic_key,
  output logic                               twe,
  output logic [TI_W-1:0]                    twaddr,
  output logic [TE_W-1:0]                    twdata,
  output logic [TI_W-1:0]                    traddr,
  input  logic [TE_W-1:0]                    trdata,
  output logic                               swe,
  output logic [SA_W-1:0]                    swaddr,
  output logic [CLIENT_BITS-1:0]             swdata,
  output logic [SA_W-1:0]                    sraddr,
  input  logic [CLIENT_BITS-1:0]             srdata,
  input  logic                               pend_full,
  output logic                               res_valid,
  output tst_pkg::result_t                   res
);

  localparam int TC_W = $clog2(MAX_TOPICS + 1);

  tst_pkg::state_t  state, state_next;
  tst_pkg::opcode_t op_q;
  logic [CLIENT_BITS-1:0] client_q;
  logic [CLIENT_BITS-1:0] client_in;
  logic [KEY_BITS-1:0]    key_q;
  logic [TC_W-1:0]        topic_count;
  logic [TI_W-1:0]        idx_q;
  logic [TI_W-1:0]        tsel_q;
  logic [SC_W-1:0]        tcnt_q;
  logic [SI_W-1:0]        cidx_q;

  logic            accept;
  logic [TC_W-1:0] tnext;
  logic            tlast, thit, tcount_full;
  logic [SC_W-1:0] trd_cnt;
  logic [SC_W-1:0] cpos, cnext, c2;
  logic            chit, clast, shift_end, slist_full;
  logic            is_sub;
  tst_pkg::status_t res_status;

  generate
    if (CLIENT_BITS <= tst_pkg::CLIENT_PORT_W) begin : g_cl_trunc
      assign client_in = client_id[CLIENT_BITS-1:0];
    end else begin : g_cl_ext
      assign client_in = {{(CLIENT_BITS - tst_pkg::CLIENT_PORT_W){1'b0}}, client_id};
    end
  endgenerate

  assign accept      = (state == tst_pkg::S_IDLE) && in_valid && !pend_full;
  assign is_sub      = (op_q == tst_pkg::OP_SUBSCRIBE);

  assign tnext       = TC_W'(idx_q) + TC_W'(1);
  assign tlast       = (tnext == topic_count);
  assign thit        = (trdata[KEY_BITS-1:0] == key_q);
  assign trd_cnt     = trdata[TE_W-1:KEY_BITS];
  assign tcount_full = (topic_count == TC_W'(MAX_TOPICS));

  assign cpos        = SC_W'(cidx_q);
  assign cnext       = cpos + SC_W'(1);
  assign c2          = cpos + SC_W'(2);
  // entries at or above the count hold stale data and never match
  assign chit        = (cpos < tcnt_q) && (srdata == client_q);
  assign clast       = (cnext >= tcnt_q);
  assign shift_end   = (c2 >= tcnt_q);
  assign slist_full  = (tcnt_q == SC_W'(MAX_SUBSCRIBERS));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tst_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (topic_count == '0) ? tst_pkg::S_TMISS : tst_pkg::S_TSCAN;
        end
      end
      tst_pkg::S_TSCAN: begin
        if (thit) begin
          state_next = tst_pkg::S_CSCAN;
        end else if (tlast) begin
          state_next = tst_pkg::S_TMISS;
        end
      end
      tst_pkg::S_TMISS: begin
        state_next = tst_pkg::S_IDLE;
      end
      tst_pkg::S_CSCAN: begin
        if (chit) begin
          state_next = (is_sub || clast) ? tst_pkg::S_IDLE : tst_pkg::S_SHIFT;
        end else if (clast) begin
          state_next = tst_pkg::S_IDLE;
        end
      end
      tst_pkg::S_SHIFT: begin
        if (shift_end) begin
          state_next = tst_pkg::S_IDLE;
        end
      end
      default: state_next = tst_pkg::S_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_stall   = 1'b1;
    traddr     = '0;
    sraddr     = '0;
    twe        = 1'b0;
    twaddr     = tsel_q;
    twdata     = {tcnt_q, key_q};
    swe        = 1'b0;
    swaddr     = {tsel_q, cidx_q};
    swdata     = client_q;
    res_valid  = 1'b0;
    res_status = tst_pkg::STAT_FULL;
    case (state)
      tst_pkg::S_IDLE: begin
        in_stall = pend_full;
      end
      tst_pkg::S_TSCAN: begin
        traddr = tnext[TI_W-1:0];
        sraddr = {idx_q, {SI_W{1'b0}}};
      end
      tst_pkg::S_TMISS: begin
        res_valid = 1'b1;
        if (!is_sub) begin
          res_status = tst_pkg::STAT_NO_TOPIC;
        end else if (tcount_full) begin
          res_status = tst_pkg::STAT_FULL;
        end else begin
          twe        = 1'b1;
          twaddr     = topic_count[TI_W-1:0];
          twdata     = {SC_W'(1), key_q};
          swe        = 1'b1;
          swaddr     = {topic_count[TI_W-1:0], {SI_W{1'b0}}};
          res_status = tst_pkg::STAT_NEW_TOPIC;
        end
      end
      tst_pkg::S_CSCAN: begin
        sraddr = {tsel_q, cnext[SI_W-1:0]};
        if (chit) begin
          if (is_sub) begin
            res_valid  = 1'b1;
            res_status = tst_pkg::STAT_ALREADY;
          end else if (clast) begin
            // last entry removed: nothing to move up
            twe        = 1'b1;
            twdata     = {tcnt_q - SC_W'(1), key_q};
            res_valid  = 1'b1;
            res_status = tst_pkg::STAT_REMOVED;
          end
        end else if (clast) begin
          res_valid = 1'b1;
          if (!is_sub) begin
            res_status = tst_pkg::STAT_NOT_SUB;
          end else if (slist_full) begin
            res_status = tst_pkg::STAT_FULL;
          end else begin
            swe        = 1'b1;
            swaddr     = {tsel_q, tcnt_q[SI_W-1:0]};
            twe        = 1'b1;
            twdata     = {tcnt_q + SC_W'(1), key_q};
            res_status = tst_pkg::STAT_ADDED;
          end
        end
      end
      tst_pkg::S_SHIFT: begin
        // read runs one entry ahead of the write
        swe    = 1'b1;
        swdata = srdata;
        sraddr = {tsel_q, c2[SI_W-1:0]};
        if (shift_end) begin
          twe        = 1'b1;
          twdata     = {tcnt_q - SC_W'(1), key_q};
          res_valid  = 1'b1;
          res_status = tst_pkg::STAT_REMOVED;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign res.status  = res_status;
  assign res.success = (res_status == tst_pkg::STAT_NEW_TOPIC) ||
                       (res_status == tst_pkg::STAT_ADDED) ||
                       (res_status == tst_pkg::STAT_REMOVED);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tst_pkg::S_IDLE;
      topic_count <= '0;
    end else begin
      state <= state_next;
      if (state == tst_pkg::S_TMISS && is_sub && !tcount_full) begin
        topic_count <= topic_count + TC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tst_pkg::S_IDLE: begin
        if (accept) begin
          op_q     <= tst_pkg::opcode_t'(opcode);
          client_q <= client_in;
          key_q    <= topic_key[KEY_BITS-1:0];
          idx_q    <= '0;
        end
      end
      tst_pkg::S_TSCAN: begin
        if (thit) begin
          tsel_q <= idx_q;
          tcnt_q <= trd_cnt;
          cidx_q <= '0;
        end else begin
          idx_q <= tnext[TI_W-1:0];
        end
      end
      tst_pkg::S_CSCAN: begin
        if (!chit && !clast) begin
          cidx_q <= cnext[SI_W-1:0];
        end
      end
      tst_pkg::S_SHIFT: begin
        if (!shift_end) begin
          cidx_q <= cnext[SI_W-1:0];
        end
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

endmodule

FILE: sv/topic_subscription_table.sv
// Sequence: the topic entries are scanned, then the chosen subscriber list (an empty list
// still takes a scan step), entries are moved up after a removal or a new topic is created,
// and the result word goes through the result register.
// Throughput: one request at a time; with no output stall the next is taken in the cycle
// the result word shows.
// Reset clears topic count, sequencer and result register; RAMs are read below counts only.
// ----------------------------------------------------------------------------
// topic_subscription_table
// Publish/subscribe topic table: topic keys with ordered subscriber lists,
// held in two RAMs and updated by read-modify-write.
// ----------------------------------------------------------------------------
module topic_subscription_table #(
  parameter int MAX_TOPICS      = tst_pkg::DEF_MAX_TOPICS,
  parameter int MAX_SUBSCRIBERS = tst_pkg::DEF_MAX_SUBSCRIBERS,
  parameter int KEY_BITS        = tst_pkg::DEF_KEY_BITS,
  parameter int CLIENT_BITS     = tst_pkg::DEF_CLIENT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [tst_pkg::CLIENT_PORT_W-1:0] client_id,
  input  logic [tst_pkg::KEY_PORT_W-1:0]    topic_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              success,
  output logic [2:0]                        status
);

  localparam int TI_W     = $clog2(MAX_TOPICS);
  localparam int SI_W     = $clog2(MAX_SUBSCRIBERS);
  localparam int SC_W     = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int TE_W     = SC_W + KEY_BITS;
  localparam int SA_W     = TI_W + SI_W;
  localparam int SUB_DEPTH = MAX_TOPICS << SI_W;

  logic                   twe, swe;
  logic [TI_W-1:0]        twaddr, traddr;
  logic [TE_W-1:0]        twdata, trdata;
  logic [SA_W-1:0]        swaddr, sraddr;
  logic [CLIENT_BITS-1:0] swdata, srdata;
  logic                   pend_full;
  logic                   res_valid;
  tst_pkg::result_t       res;

  tst_ctrl #(
    .MAX_TOPICS      (MAX_TOPICS),
    .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
    .KEY_BITS        (KEY_BITS),
    .CLIENT_BITS     (CLIENT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .client_id (client_id),
    .topic_key (topic_key),
    .twe       (twe),
    .twaddr    (twaddr),
    .twdata    (twdata),
    .traddr    (traddr),
    .trdata    (trdata),
    .swe       (swe),
    .swaddr    (swaddr),
    .swdata    (swdata),
    .sraddr    (sraddr),
    .srdata    (srdata),
    .pend_full (pend_full),
    .res_valid (res_valid),
    .res       (res)
  );

  tst_ram #(
    .WIDTH (TE_W),
    .DEPTH (MAX_TOPICS)
  ) u_topic_ram (
    .clk   (clk),
    .we    (twe),
    .waddr (twaddr),
    .wdata (twdata),
    .raddr (traddr),
    .rdata (trdata)
  );

  tst_ram #(
    .WIDTH (CLIENT_BITS),
    .DEPTH (SUB_DEPTH)
  ) u_sub_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (swaddr),
    .wdata (swdata),
    .raddr (sraddr),
    .rdata (srdata)
  );

  tst_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .pend_full (pend_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .success   (success),
    .status    (status)
  );

endmodule

FILE: sv/tst_checker.sv
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks on the topic subscription table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              opcode,
  input logic [tst_pkg::CLIENT_PORT_W-1:0] client_id,
  input logic [tst_pkg::KEY_PORT_W-1:0]    topic_key,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              success,
  input logic [2:0]                        status
);

  // one request in flight: the input closes straight after a word is taken
  `TST_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)

  `TST_ASSERT(a_success_matches, out_valid |-> (success == ((status == tst_pkg::STAT_NEW_TOPIC) || (status == tst_pkg::STAT_ADDED) || (status == tst_pkg::STAT_REMOVED))))

  `TST_ASSERT(a_status_legal, out_valid |-> (status <= tst_pkg::STAT_FULL))

  `TST_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(success)))

  `TST_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind topic_subscription_table tst_checker u_tst_checker (.*);

FILE: tb/sv/tb_topic_subscription_table.sv
// ----------------------------------------------------------------------------
// tb_topic_subscription_table
// Self-checking bench for the topic subscription table: a scoreboard keeps
// its own copy of the topic keys and subscriber lists, predicts each status
// word and checks it against the block under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_topic_subscription_table;
  timeunit 1ns;
  timeprecision 1ps;

  import tst_pkg::*;

  localparam int N_TOPICS = DEF_MAX_TOPICS;
  localparam int N_SUBS   = DEF_MAX_SUBSCRIBERS;
  localparam logic [KEY_PORT_W-1:0] KEY_MASK =
    {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - DEF_KEY_BITS);
  localparam logic [CLIENT_PORT_W-1:0] CLIENT_MASK =
    {CLIENT_PORT_W{1'b1}} >> (CLIENT_PORT_W - DEF_CLIENT_BITS);
  localparam int SETTLE_CYCLES  = N_TOPICS + N_SUBS + 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 282;
  localparam int N_CLIENT_POOL  = 24;

  typedef struct packed {
    opcode_t                  op;
    logic [CLIENT_PORT_W-1:0] cid;
    logic [KEY_PORT_W-1:0]    tkey;
  } request_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = 1'b0;
  logic [CLIENT_PORT_W-1:0] client_id = '0;
  logic [KEY_PORT_W-1:0]    topic_key = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     success;
  logic [2:0]               status;

  request_t pending_reqs[$];
  result_t  due_results[$];

  // scoreboard copy of the table
  logic [KEY_PORT_W-1:0]    known_keys[N_TOPICS];
  int                       n_topics = 0;
  logic [CLIENT_PORT_W-1:0] roster[N_TOPICS][N_SUBS];
  int                       roster_len[N_TOPICS];

  logic [KEY_PORT_W-1:0]    key_pool[N_TOPICS];
  logic [CLIENT_PORT_W-1:0] client_pool[N_CLIENT_POOL];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int words_checked = 0;
  int quiet_cycles  = 0;

  topic_subscription_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .client_id (client_id),
    .topic_key (topic_key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .success   (success),
    .status    (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Updates the scoreboard table and returns the status word it implies.
  function automatic result_t apply_request(opcode_t op, logic [CLIENT_PORT_W-1:0] cid,
                                            logic [KEY_PORT_W-1:0] tkey);
    logic [KEY_PORT_W-1:0]    k;
    logic [CLIENT_PORT_W-1:0] c;
    int                       t;
    int                       pos;
    result_t                  r;
    k   = tkey & KEY_MASK;
    c   = cid & CLIENT_MASK;
    t   = -1;
    pos = -1;
    for (int i = 0; i < n_topics; i++)
      if (known_keys[i] == k) t = i;
    if (t >= 0) begin
      for (int i = 0; i < roster_len[t]; i++)
        if (roster[t][i] == c) pos = i;
    end
    if (op == OP_SUBSCRIBE) begin
      if (t < 0) begin
        if (n_topics >= N_TOPICS) begin
          r.status = STAT_FULL;
        end else begin
          known_keys[n_topics] = k;
          roster[n_topics][0]  = c;
          roster_len[n_topics] = 1;
          n_topics++;
          r.status = STAT_NEW_TOPIC;
        end
      end else if (pos >= 0) begin
        r.status = STAT_ALREADY;
      end else if (roster_len[t] >= N_SUBS) begin
        r.status = STAT_FULL;
      end else begin
        roster[t][roster_len[t]] = c;
        roster_len[t]++;
        r.status = STAT_ADDED;
      end
    end else begin
      if (t < 0) begin
        r.status = STAT_NO_TOPIC;
      end else if (pos < 0) begin
        r.status = STAT_NOT_SUB;
      end else begin
        // close the gap, later subscribers keep their order
        for (int i = pos; i + 1 < roster_len[t]; i++)
          roster[t][i] = roster[t][i + 1];
        roster_len[t]--;
        r.status = STAT_REMOVED;
      end
    end
    r.success = (r.status == STAT_NEW_TOPIC || r.status == STAT_ADDED ||
                 r.status == STAT_REMOVED);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch on word %0d: %s", words_checked, msg);
    mismatches++;
  endtask

  task automatic queue_req(input opcode_t op, input logic [CLIENT_PORT_W-1:0] cid,
                           input logic [KEY_PORT_W-1:0] tkey);
    request_t q;
    q.op   = op;
    q.cid  = cid;
    q.tkey = tkey;
    pending_reqs.push_back(q);
  endtask

  // Mostly pool clients and pool topics so lists fill and drain; some noise.
  task automatic queue_random_req();
    opcode_t                  op;
    logic [CLIENT_PORT_W-1:0] cid;
    logic [KEY_PORT_W-1:0]    tkey;
    op   = ($urandom_range(99) < 62) ? OP_SUBSCRIBE : OP_UNSUBSCRIBE;
    cid  = ($urandom_range(99) < 88) ? client_pool[$urandom_range(N_CLIENT_POOL - 1)]
                                     : CLIENT_PORT_W'($urandom);
    tkey = ($urandom_range(99) < 92) ? key_pool[$urandom_range(N_TOPICS - 1)]
                                     : {$urandom, $urandom};
    queue_req(op, cid, tkey);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        due_results.push_back(apply_request(opcode_t'(opcode), client_id, topic_key));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          opcode    <= nxt.op;
          client_id <= nxt.cid;
          topic_key <= nxt.tkey;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_word;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("status word with nothing outstanding");
        end else begin
          exp_word = due_results.pop_front();
          if (success !== exp_word.success)
            report_mismatch($sformatf("success %b, want %b", success, exp_word.success));
          if (status !== exp_word.status)
            report_mismatch($sformatf("status %0d, want %0d", status, exp_word.status));
        end
        words_checked++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: cycles without a word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < N_TOPICS; i++) roster_len[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {1'b1, {(KEY_PORT_W - 1){1'b0}}};
    for (int i = 3; i < N_TOPICS; i++) key_pool[i] = {$urandom, $urandom};
    client_pool[0] = '0;
    client_pool[1] = '1;
    for (int i = 2; i < 18; i++) client_pool[i] = CLIENT_PORT_W'(i - 1);
    for (int i = 18; i < N_CLIENT_POOL; i++) client_pool[i] = CLIENT_PORT_W'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed opening: empty table, duplicates, removal order, full list
    queue_req(OP_UNSUBSCRIBE, '0, key_pool[0]);
    queue_req(OP_SUBSCRIBE,   '0, key_pool[0]);
    queue_req(OP_SUBSCRIBE,   '0, key_pool[0]);
    queue_req(OP_SUBSCRIBE,   '1, key_pool[0]);
    queue_req(OP_UNSUBSCRIBE, CLIENT_PORT_W'(5), key_pool[0]);
    queue_req(OP_SUBSCRIBE,   '1, key_pool[1]);
    queue_req(OP_UNSUBSCRIBE, '0, key_pool[0]);
    queue_req(OP_UNSUBSCRIBE, '1, key_pool[0]);
    queue_req(OP_UNSUBSCRIBE, '1, key_pool[0]);
    for (int i = 1; i <= N_SUBS; i++)
      queue_req(OP_SUBSCRIBE, CLIENT_PORT_W'(i), key_pool[1]);

    for (int ph = 0; ph < 4; ph++) begin
      // sender holds off here until every word is back
      wait_drained();
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_req();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
